### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define LDHS_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Same, on the block clock and reset.
`define LDHS_ASSERT(lbl, prop, msg) `LDHS_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

### hw/rtl/ldhs_pkg.sv
// Package of the LOOK disk head scheduler: sizes, register indexes, state
// enums and the controller/datapath command and status structs. No dependencies.
package ldhs_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int TRACK_BITS   = 16;

	localparam int IDX_BITS    = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int TALLY_BITS  = $clog2(MAX_REQUESTS + 1);
	localparam int TC_BITS     = TRACK_BITS + 1;
	localparam int MV_BITS     = TRACK_BITS + 1;
	localparam int KEY_BITS    = TRACK_BITS + IDX_BITS;
	localparam int IN_DATA_W   = ((TRACK_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_W = TRACK_BITS + MV_BITS;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = TC_BITS;

	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_START  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP    = CFG_IDX_W'(2);

	typedef struct packed {
		logic [TC_BITS-1:0]    track_count;
		logic [TRACK_BITS-1:0] head_start;
		logic                  sweep_up;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_EQ,
		PH_UP,
		PH_DN
	} phase_t;

	typedef enum logic [1:0] {
		STEP_SAME,
		STEP_FIRST,
		STEP_SECOND
	} step_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BAD,
		ST_SCAN,
		ST_WAIT,
		ST_NEXT,
		ST_PUSH,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic   load;
		logic   init_run;
		logic   clear_batch;
		logic   scan_init;
		logic   scan_rd;
		logic   phase_init;
		logic   visit;
		logic   push;
		logic   push_last;
		logic   push_bad;
		phase_t phase;
	} cmd_t;

	typedef struct packed {
		logic last_bad;
		logic tally_zero;
		logic scan_last;
		logic found;
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/ldhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ldhs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/ldhs_cfg.sv
// Configuration registers of the scheduler: track count, head start, sweep direction.
// Depends on ldhs_pkg.
module ldhs_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ldhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ldhs_pkg::CFG_DATA_W-1:0] cfg_data,
	output ldhs_pkg::cfg_t                 cfg
);

	ldhs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_count <= {1'b1, {ldhs_pkg::TRACK_BITS{1'b0}}};
			cfg_q.head_start  <= '0;
			cfg_q.sweep_up    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				ldhs_pkg::CFG_TRACK_COUNT: begin
					cfg_q.track_count <= cfg_data;
				end
				ldhs_pkg::CFG_HEAD_START: begin
					cfg_q.head_start <= cfg_data[ldhs_pkg::TRACK_BITS-1:0];
				end
				ldhs_pkg::CFG_SWEEP_UP: begin
					cfg_q.sweep_up <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

endmodule

### hw/rtl/ldhs_ctrl.sv
// Controller FSM: batch loading, scan passes per sweep phase, result pushes.
// Depends on ldhs_pkg.
module ldhs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	input  logic           sweep_up,
	input  ldhs_pkg::sts_t sts,
	output logic           in_ready,
	output ldhs_pkg::cmd_t cmd
);

	ldhs_pkg::state_t state_q, state_d;
	ldhs_pkg::step_t  step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldhs_pkg::ST_LOAD;
			step_q  <= ldhs_pkg::STEP_SAME;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		in_ready = 1'b0;
		cmd      = '0;

		case (step_q)
			ldhs_pkg::STEP_SAME:  cmd.phase = ldhs_pkg::PH_EQ;
			ldhs_pkg::STEP_FIRST: cmd.phase = sweep_up ? ldhs_pkg::PH_UP : ldhs_pkg::PH_DN;
			default:              cmd.phase = sweep_up ? ldhs_pkg::PH_DN : ldhs_pkg::PH_UP;
		endcase

		case (state_q)
			ldhs_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						if (sts.last_bad) begin
							state_d = ldhs_pkg::ST_BAD;
						end else begin
							cmd.init_run   = 1'b1;
							cmd.scan_init  = 1'b1;
							cmd.phase_init = 1'b1;
							step_d         = ldhs_pkg::STEP_SAME;
							state_d        = ldhs_pkg::ST_SCAN;
						end
					end
				end
			end
			ldhs_pkg::ST_BAD: begin
				if (sts.out_free) begin
					cmd.push        = 1'b1;
					cmd.push_bad    = 1'b1;
					cmd.push_last   = 1'b1;
					cmd.clear_batch = 1'b1;
					state_d         = ldhs_pkg::ST_LOAD;
				end
			end
			ldhs_pkg::ST_SCAN: begin
				if (sts.tally_zero) begin
					state_d = ldhs_pkg::ST_NEXT;
				end else begin
					cmd.scan_rd = 1'b1;
					if (sts.scan_last) begin
						state_d = ldhs_pkg::ST_WAIT;
					end
				end
			end
			ldhs_pkg::ST_WAIT: begin
				state_d = ldhs_pkg::ST_NEXT;
			end
			ldhs_pkg::ST_NEXT: begin
				if (sts.found) begin
					state_d = ldhs_pkg::ST_PUSH;
				end else if (step_q == ldhs_pkg::STEP_SECOND) begin
					state_d = ldhs_pkg::ST_FIN;
				end else begin
					step_d = (step_q == ldhs_pkg::STEP_SAME) ?
						ldhs_pkg::STEP_FIRST : ldhs_pkg::STEP_SECOND;
					cmd.phase_init = 1'b1;
					cmd.scan_init  = 1'b1;
					state_d        = ldhs_pkg::ST_SCAN;
				end
			end
			ldhs_pkg::ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.visit     = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = ldhs_pkg::ST_SCAN;
				end
			end
			ldhs_pkg::ST_FIN: begin
				if (sts.out_free) begin
					cmd.push        = 1'b1;
					cmd.push_last   = 1'b1;
					cmd.clear_batch = 1'b1;
					state_d         = ldhs_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = ldhs_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

### hw/rtl/ldhs_dp.sv
// Datapath: request RAM, batch checks, next-track search, head/movement, output reg.
// Depends on ldhs_pkg and ldhs_ram.
module ldhs_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ldhs_pkg::cfg_t                 cfg,
	input  ldhs_pkg::cmd_t                 cmd,
	input  logic [ldhs_pkg::TRACK_BITS-1:0] in_track,
	input  logic                           in_req_valid,
	input  logic                           out_ready,
	output ldhs_pkg::sts_t                 sts,
	output logic                           out_valid,
	output logic [ldhs_pkg::TRACK_BITS-1:0] out_track,
	output logic [ldhs_pkg::MV_BITS-1:0]    out_mv,
	output logic                           out_bad,
	output logic                           out_last
);

	logic [ldhs_pkg::TALLY_BITS-1:0] tally_q;
	logic                            err_q;
	logic [ldhs_pkg::TRACK_BITS-1:0] head_q;
	logic [ldhs_pkg::MV_BITS-1:0]    mv_q;
	logic [ldhs_pkg::KEY_BITS-1:0]   cur_q;
	logic [ldhs_pkg::KEY_BITS-1:0]   best_q;
	logic                            found_q;
	logic                            first_q;
	logic [ldhs_pkg::IDX_BITS-1:0]   rd_idx_q;
	logic                            cmp_en_s1;
	logic [ldhs_pkg::IDX_BITS-1:0]   idx_s1;
	logic                            out_valid_q;
	logic [ldhs_pkg::TRACK_BITS-1:0] out_track_q;
	logic [ldhs_pkg::MV_BITS-1:0]    out_mv_q;
	logic                            out_bad_q;
	logic                            out_last_q;

	logic                            full;
	logic                            req_oor;
	logic                            start_oor;
	logic                            ram_we;
	logic [ldhs_pkg::TRACK_BITS-1:0] ram_rdata;
	logic [ldhs_pkg::KEY_BITS-1:0]   cand_key;
	logic                            above;
	logic                            below;
	logic                            qual;
	logic                            better;
	logic                            take;
	logic [ldhs_pkg::TRACK_BITS-1:0] best_v;
	logic [ldhs_pkg::TRACK_BITS-1:0] delta;
	logic [ldhs_pkg::MV_BITS-1:0]    mv_next;

	assign full      = (tally_q == ldhs_pkg::TALLY_BITS'(ldhs_pkg::MAX_REQUESTS));
	assign req_oor   = ({1'b0, in_track} >= cfg.track_count);
	assign start_oor = ({1'b0, cfg.head_start} >= cfg.track_count);
	assign ram_we    = cmd.load & in_req_valid & ~full;

	ldhs_ram #(
		.WIDTH(ldhs_pkg::TRACK_BITS),
		.DEPTH(ldhs_pkg::MAX_REQUESTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tally_q[ldhs_pkg::IDX_BITS-1:0]),
		.wdata(in_track),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	// entries are ordered by {track, slot} so duplicates are visited one by one
	assign cand_key = {ram_rdata, idx_s1};
	assign above    = (cand_key > cur_q);
	assign below    = (cand_key < cur_q);

	always_comb begin
		case (cmd.phase)
			ldhs_pkg::PH_EQ: qual = (ram_rdata == cfg.head_start) && (first_q || above);
			ldhs_pkg::PH_UP: qual = (ram_rdata > cfg.head_start) && (first_q || above);
			default:         qual = (ram_rdata < cfg.head_start) && (first_q || below);
		endcase
	end

	assign better = ~found_q ||
		((cmd.phase == ldhs_pkg::PH_DN) ? (cand_key > best_q) : (cand_key < best_q));
	assign take   = cmp_en_s1 & qual & better;

	assign best_v  = best_q[ldhs_pkg::KEY_BITS-1 -: ldhs_pkg::TRACK_BITS];
	assign delta   = (best_v >= head_q) ? (best_v - head_q) : (head_q - best_v);
	assign mv_next = mv_q + ldhs_pkg::MV_BITS'(delta);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= '0;
			err_q       <= 1'b0;
			found_q     <= 1'b0;
			first_q     <= 1'b1;
			rd_idx_q    <= '0;
			cmp_en_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_batch) begin
				tally_q <= '0;
				err_q   <= 1'b0;
			end else if (cmd.load && in_req_valid) begin
				if (!full) begin
					tally_q <= tally_q + ldhs_pkg::TALLY_BITS'(1);
				end
				if (full || req_oor) begin
					err_q <= 1'b1;
				end
			end

			if (cmd.scan_init) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					rd_idx_q <= rd_idx_q + ldhs_pkg::IDX_BITS'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			cmp_en_s1 <= cmd.scan_rd;

			if (cmd.phase_init) begin
				first_q <= 1'b1;
			end else if (cmd.visit) begin
				first_q <= 1'b0;
			end

			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (take) begin
			best_q <= cand_key;
		end
		if (cmd.init_run) begin
			head_q <= cfg.head_start;
			mv_q   <= '0;
		end else if (cmd.visit) begin
			head_q <= best_v;
			mv_q   <= mv_next;
			cur_q  <= best_q;
		end
		if (cmd.push) begin
			out_track_q <= cmd.push_bad ? '0 : head_q;
			out_mv_q    <= cmd.push_bad ? '0 : mv_q;
			out_bad_q   <= cmd.push_bad;
			out_last_q  <= cmd.push_last;
		end
	end

	assign sts.last_bad   = err_q | (in_req_valid & (full | req_oor)) | start_oor;
	assign sts.tally_zero = (tally_q == '0);
	assign sts.scan_last  = ((ldhs_pkg::TALLY_BITS'(rd_idx_q) + ldhs_pkg::TALLY_BITS'(1))
		== tally_q);
	assign sts.found      = found_q;
	assign sts.out_free   = ~out_valid_q | out_ready;

	assign out_valid = out_valid_q;
	assign out_track = out_track_q;
	assign out_mv    = out_mv_q;
	assign out_bad   = out_bad_q;
	assign out_last  = out_last_q;

endmodule

### hw/rtl/look_disk_head_scheduler_top.sv
// LOOK disk head scheduler, top level. Requests load one per cycle into a RAM while
// the block is in its load state. After the last request, each visit takes one scan and
// a push; three empty scans end the run, and output stalls hold the pushes. A rejected
// batch pushes a single result once the output is free.
// arst_n clears control and loads the register reset values; the RAM is not cleared.
// Depends on ldhs_pkg, ldhs_cfg, ldhs_ctrl, ldhs_dp, ldhs_ram.
module look_disk_head_scheduler_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [ldhs_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // request_track
	input  logic                           s_axis_tuser,  // request_valid
	input  logic                           s_axis_tlast,  // batch_last
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [ldhs_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // visited_track, movement_so_far
	output logic                           m_axis_tuser,  // bad_batch
	output logic                           m_axis_tlast,  // run_last
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ldhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ldhs_pkg::CFG_DATA_W-1:0] cfg_data
);

	ldhs_pkg::cfg_t                  cfg;
	ldhs_pkg::cmd_t                  cmd;
	ldhs_pkg::sts_t                  sts;
	logic [ldhs_pkg::TRACK_BITS-1:0] out_track;
	logic [ldhs_pkg::MV_BITS-1:0]    out_mv;

	ldhs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	ldhs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_last (s_axis_tlast),
		.sweep_up(cfg.sweep_up),
		.sts     (sts),
		.in_ready(s_axis_tready),
		.cmd     (cmd)
	);

	ldhs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.in_track    (s_axis_tdata[ldhs_pkg::TRACK_BITS-1:0]),
		.in_req_valid(s_axis_tuser),
		.out_ready   (m_axis_tready),
		.sts         (sts),
		.out_valid   (m_axis_tvalid),
		.out_track   (out_track),
		.out_mv      (out_mv),
		.out_bad     (m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = ldhs_pkg::OUT_DATA_W'({out_mv, out_track});

endmodule

### hw/rtl/ldhs_checker.sv
// Port-level checks for the scheduler top, bound to it below.
// Depends on ldhs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ldhs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           s_axis_tlast,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ldhs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tuser,
	input logic                           m_axis_tlast
);

	`LDHS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output request changed while stalled")
	`LDHS_ASSERT(a_bad_single, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0), "bad batch result not a single zero result")
	`LDHS_ASSERT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready, "input taken right after batch close")
	`LDHS_ASSERT(a_no_load_mid_run, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input taken while a schedule is in progress")

endmodule

bind look_disk_head_scheduler_top ldhs_checker u_ldhs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

### tb/sv/look_disk_head_scheduler_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for look_disk_head_scheduler_top: directed and random request
// batches under several register settings, LOOK walk predicted in-bench per result.
// Depends on ldhs_pkg and the scheduler RTL.
module look_disk_head_scheduler_top_test;
	import ldhs_pkg::*;

	typedef struct {
		logic [TRACK_BITS-1:0] track;
		logic                  has_req;
		logic                  closes;
		logic                  wait_drain;
	} req_t;

	typedef struct {
		logic [TRACK_BITS-1:0] track;
		logic [MV_BITS-1:0]    moved;
		logic                  bad;
		logic                  run_end;
	} stop_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // request_track
	logic                  s_axis_tuser = 1'b0; // request_valid
	logic                  s_axis_tlast = 1'b0; // batch_last
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // visited_track, movement_so_far
	logic                  m_axis_tuser;        // bad_batch
	logic                  m_axis_tlast;        // run_last
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_TRACK_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copy used for prediction
	int unsigned           tc_now = 65536;
	logic [TRACK_BITS-1:0] start_now = '0;
	logic                  up_now = 1'b1;

	// batch being collected
	logic [TRACK_BITS-1:0] batch_tracks [$];
	logic                  batch_bad = 1'b0;

	req_t        pending_reqs [$];
	stop_t       due_stops [$];
	req_t        cur_req;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned long_holds_asked = 0;
	int unsigned long_holds_given = 0;
	logic        calm = 1'b0;
	int unsigned queued_total = 0;
	int unsigned accepted_total = 0;
	int unsigned live_items = 0;
	int unsigned errors = 0;
	int unsigned stops_checked = 0;
	int unsigned batches_closed = 0;
	int unsigned batches_bad = 0;
	int unsigned settings_used = 0;

	look_disk_head_scheduler_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic stop_t mk_stop(input logic [TRACK_BITS-1:0] track,
			input logic [MV_BITS-1:0] moved, input logic bad, input logic run_end);
		stop_t s;
		s.track = track;
		s.moved = moved;
		s.bad = bad;
		s.run_end = run_end;
		return s;
	endfunction

	function automatic void add_stop(input stop_t s);
		due_stops.insert(due_stops.size(), s);
	endfunction

	function automatic int unsigned next_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Collect one request; on batch close, queue the whole LOOK walk.
	task automatic look_walk(input req_t it);
		logic [TRACK_BITS-1:0] order [MAX_REQUESTS];
		logic [TRACK_BITS-1:0] v;
		logic                  go_up;
		int n, i, j, p, k, head, moved, vv;
		if (it.has_req) begin
			if (it.track >= tc_now) batch_bad = 1'b1;
			if (batch_tracks.size() < MAX_REQUESTS)
				batch_tracks.insert(batch_tracks.size(), it.track);
			else batch_bad = 1'b1;
		end
		if (!it.closes) return;
		batches_closed++;
		if (start_now >= tc_now) batch_bad = 1'b1;
		if (batch_bad) begin
			add_stop(mk_stop('0, '0, 1'b1, 1'b1));
			batches_bad++;
		end else begin
			n = batch_tracks.size();
			for (i = 0; i < n; i++) order[i] = batch_tracks[i];
			for (i = 1; i < n; i++) begin
				v = order[i];
				j = i;
				while (j > 0 && order[j-1] > v) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = v;
			end
			head = start_now;
			moved = 0;
			k = 0;
			add_stop(mk_stop(start_now, '0, 1'b0, n == 0));
			// pass 0: tracks at the start, then the first and second sweep
			for (p = 0; p < 3; p++) begin
				go_up = (p == 1) ? up_now : !up_now;
				for (i = 0; i < n; i++) begin
					v = go_up ? order[i] : order[n-1-i];
					vv = v;
					if ((p == 0 && v == start_now) || (p != 0 && go_up && v > start_now) ||
							(p != 0 && !go_up && v < start_now)) begin
						moved += (vv > head) ? vv - head : head - vv;
						head = vv;
						k++;
						add_stop(mk_stop(v, MV_BITS'(moved), 1'b0, k == n));
					end
				end
			end
		end
		batch_tracks.delete();
		batch_bad = 1'b0;
	endtask

	// request driver
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			look_walk(cur_req);
			accepted_total++;
			gap_left = next_gap();
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0 &&
					(!pending_reqs[0].wait_drain || due_stops.size() == 0)) begin
				cur_req = pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= IN_DATA_W'(cur_req.track);
				s_axis_tuser <= cur_req.has_req;
				s_axis_tlast <= cur_req.closes;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin : result_mon
		stop_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = mk_stop(m_axis_tdata[TRACK_BITS-1:0],
				m_axis_tdata[TRACK_BITS+MV_BITS-1:TRACK_BITS], m_axis_tuser, m_axis_tlast);
			if (due_stops.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, got track %0d moved %0d bad %0b last %0b",
					$time, got.track, got.moved, got.bad, got.run_end);
			end else begin
				want = due_stops.pop_front();
				stops_checked++;
				if (got.track !== want.track || got.moved !== want.moved ||
						got.bad !== want.bad || got.run_end !== want.run_end) begin
					errors++;
					$display("%0t: mismatch, expected track %0d moved %0d bad %0b last %0b",
						$time, want.track, want.moved, want.bad, want.run_end);
					$display("%0t:           got track %0d moved %0d bad %0b last %0b",
						$time, got.track, got.moved, got.bad, got.run_end);
				end
			end
		end
		if (long_holds_asked != long_holds_given) begin
			long_holds_given++;
			hold_left = 300;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (calm || $urandom_range(0, 99) < 70) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
			hold_left = next_gap();
		end
	end

	task automatic queue_req(input logic [TRACK_BITS-1:0] track, input logic has_req,
			input logic closes, input logic wait_drain);
		req_t it;
		it.track = track;
		it.has_req = has_req;
		it.closes = closes;
		it.wait_drain = wait_drain;
		pending_reqs.insert(pending_reqs.size(), it);
		queued_total++;
		if (has_req || closes) live_items++;
	endtask

	task automatic apply_settings(input int unsigned tc, input logic [TRACK_BITS-1:0] start,
			input logic up);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] val [3];
		int i;
		idx[0] = CFG_TRACK_COUNT;
		val[0] = CFG_DATA_W'(tc);
		idx[1] = CFG_HEAD_START;
		val[1] = CFG_DATA_W'(start);
		idx[2] = CFG_SWEEP_UP;
		val[2] = CFG_DATA_W'(up);
		for (i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		tc_now = tc;
		start_now = start;
		up_now = up;
		settings_used++;
	endtask

	// wait for all requests taken and all results seen, then let the block settle
	task automatic drain_all();
		while (accepted_total != queued_total || due_stops.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	function automatic logic [TRACK_BITS-1:0] pick_track();
		int unsigned r, hi, s;
		r = $urandom_range(0, 99);
		hi = (tc_now > 65536) ? 65535 : tc_now - 1;
		s = start_now;
		if (r < 15) return start_now;
		if (r < 21) return TRACK_BITS'($urandom);
		if (r < 36) begin
			s = s + $urandom_range(0, 6);
			s = (s < 3) ? 0 : s - 3;
			return TRACK_BITS'((s > hi) ? hi : s);
		end
		if (r < 40) return '0;
		if (r < 45) return TRACK_BITS'(hi);
		return TRACK_BITS'($urandom_range(0, hi));
	endfunction

	function automatic int batch_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12) return 0;
		if (r < 75) return $urandom_range(1, 6);
		if (r < 94) return $urandom_range(7, 20);
		return $urandom_range(29, MAX_REQUESTS + 2);
	endfunction

	// n requests; the closing item carries the last one or none
	task automatic queue_batch(input int n, input logic wait_drain);
		int   i;
		logic tail_has;
		logic hold;
		hold = wait_drain;
		tail_has = (n > 0) && ($urandom_range(0, 1) == 1);
		for (i = 0; i < n - tail_has; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				queue_req(TRACK_BITS'($urandom), 1'b0, 1'b0, hold);
				hold = 1'b0;
			end
			queue_req(pick_track(), 1'b1, 1'b0, hold);
			hold = 1'b0;
		end
		queue_req(tail_has ? pick_track() : TRACK_BITS'($urandom), tail_has, 1'b1, hold);
	endtask

	initial begin : stimulus
		int unsigned ph, goal, phase_goal, tc, nb;
		logic [TRACK_BITS-1:0] st;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty batch, extremes with a request at the start
		queue_req('0, 1'b0, 1'b1, 1'b0);
		queue_req(16'd65535, 1'b1, 1'b0, 1'b0);
		queue_req(16'd0, 1'b1, 1'b0, 1'b0);
		queue_req(16'd1, 1'b1, 1'b1, 1'b0);
		drain_all();

		// down first, ignored item inside, then a request equal to track_count
		apply_settings(100, 16'd50, 1'b0);
		queue_req(16'd50, 1'b1, 1'b0, 1'b0);
		queue_req(16'd77, 1'b0, 1'b0, 1'b0);
		queue_req(16'd10, 1'b1, 1'b0, 1'b0);
		queue_req(16'd99, 1'b1, 1'b0, 1'b0);
		queue_req(16'd60, 1'b1, 1'b0, 1'b0);
		queue_req(16'd49, 1'b1, 1'b0, 1'b0);
		queue_req(16'd0, 1'b0, 1'b1, 1'b0);
		queue_req(16'd100, 1'b1, 1'b1, 1'b0);
		drain_all();

		// start out of range
		apply_settings(40, 16'd40, 1'b1);
		queue_req('0, 1'b0, 1'b1, 1'b0);
		drain_all();

		apply_settings(1, 16'd0, 1'b0);
		queue_req(16'd0, 1'b1, 1'b1, 1'b0);
		queue_req(16'd1, 1'b1, 1'b1, 1'b0);
		drain_all();

		apply_settings(65536, 16'd65535, 1'b0);
		queue_req(16'd0, 1'b1, 1'b0, 1'b0);
		queue_req(16'd65535, 1'b1, 1'b0, 1'b0);
		queue_req(16'd32768, 1'b1, 1'b1, 1'b0);
		drain_all();

		goal = live_items + 460;
		for (ph = 0; live_items < goal; ph++) begin
			case (ph % 6)
				0: begin
					tc = 65536;
					st = TRACK_BITS'($urandom);
				end
				1: begin
					tc = $urandom_range(1, 64);
					st = TRACK_BITS'($urandom_range(0, tc - 1));
				end
				2: begin
					tc = 65536;
					st = $urandom_range(0, 1) ? 16'd65535 : 16'd0;
				end
				3: begin
					tc = $urandom_range(1, 65535);
					st = ($urandom_range(0, 9) == 0) ? TRACK_BITS'($urandom_range(tc, 65535))
						: TRACK_BITS'($urandom_range(0, tc - 1));
				end
				4: begin
					tc = 1;
					st = '0;
				end
				default: begin
					tc = $urandom_range(2, 4096);
					st = TRACK_BITS'(tc - 1);
				end
			endcase
			apply_settings(tc, st, 1'($urandom_range(0, 1)));
			calm = (ph % 4 == 3);
			if (ph == 2) long_holds_asked++;
			if (ph == 1) queue_batch(MAX_REQUESTS + 1, 1'b0);
			phase_goal = live_items + 46;
			nb = 0;
			while (live_items < phase_goal) begin
				queue_batch(batch_size(), (ph == 0 && nb == 1) || $urandom_range(0, 9) == 0);
				nb++;
				while (pending_reqs.size() > 8) @(posedge clk);
			end
			drain_all();
		end

		$display("Checked %0d results from %0d batches (%0d rejected) under %0d settings.",
			stops_checked, batches_closed, batches_bad, settings_used);
		$display("Sent %0d requests with random gaps, a long output stall and drain pauses.",
			accepted_total);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ldhs_pkg.sv
hw/rtl/ldhs_ram.sv
hw/rtl/ldhs_cfg.sv
hw/rtl/ldhs_ctrl.sv
hw/rtl/ldhs_dp.sv
hw/rtl/look_disk_head_scheduler_top.sv
hw/rtl/ldhs_checker.sv
tb/sv/look_disk_head_scheduler_top_test.sv
